[src/rotate_project_zbuffer_plot_defines.svh]
// assertion macros used by the point plotter controller
`ifndef ROTATE_PROJECT_ZBUFFER_PLOT_DEFINES_SVH
`define ROTATE_PROJECT_ZBUFFER_PLOT_DEFINES_SVH

// property that must hold in the same cycle as its trigger
`define RPPZ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// property that must hold in the cycle after its trigger
`define RPPZ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/rppz_pkg.sv]
// shared types and constants of the point plotter
`timescale 1ns / 1ps

package rppz_pkg;

   // field widths
   localparam int CSR_AW    = 5;
   localparam int PIX_W     = 12;
   localparam int SYM_W     = 8;
   localparam int DEPTH_W   = 24;
   localparam int WORD_W    = DEPTH_W + SYM_W;

   // datapath widths, sized to the exact product ranges
   localparam int PROD1_W   = 23;
   localparam int UV_W      = 24;
   localparam int W_W       = 40;
   localparam int M_W       = 41;
   localparam int CM_W      = 57;
   localparam int ROT_W     = 58;
   localparam int Z42_W     = 55;
   localparam int Z14_W     = 28;
   localparam int XY14_W    = 30;
   localparam int DIV_W     = 27;
   localparam int ZV_W      = 32;
   localparam int PROJ_W    = 63;
   localparam int T_W       = 66;
   localparam int CR_W      = 28;
   localparam int P_W       = 40;

   localparam logic [SYM_W-1:0]   SPACE_CODE = 8'd32;
   localparam logic [DEPTH_W-1:0] ZINV_MAX   = 24'hFF_FFFF;
   localparam logic               ACTION_READ = 1'b1;

   typedef enum logic [1:0] {
      STATUS_WRITTEN = 2'd0,
      STATUS_HIDDEN  = 2'd1,
      STATUS_DROPPED = 2'd2,
      STATUS_READ    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_SIN_A    = 3'd0,
      REG_COS_A    = 3'd1,
      REG_SIN_B    = 3'd2,
      REG_COS_B    = 3'd3,
      REG_SIN_C    = 3'd4,
      REG_COS_C    = 3'd5,
      REG_OBJ_DIST = 3'd6,
      REG_VIEW_DIST = 3'd7
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE,
      ST_ROT1, ST_ROT2, ST_ROT3, ST_ROT4, ST_ROT5, ST_ROT6, ST_ROT7,
      ST_DROP, ST_DIV,
      ST_PRJ1, ST_PRJ2, ST_PRJ3, ST_PRJ4, ST_PRJ5,
      ST_MEM_RD, ST_MEM_UPD, ST_CLR_RD, ST_CLR_UPD, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      STEP_NONE, STEP_CLEAR, STEP_LOAD,
      STEP_ROT1, STEP_ROT2, STEP_ROT3, STEP_ROT4, STEP_ROT5, STEP_ROT6, STEP_ROT7,
      STEP_DROP, STEP_DIV, STEP_ZV, STEP_PX, STEP_PY, STEP_COLROW, STEP_PIX,
      STEP_RD_PIX, STEP_UPD_PIX, STEP_RD_CELL, STEP_UPD_CELL
   } step_type;

   typedef struct packed {
      logic signed [15:0] sin_a;
      logic signed [15:0] cos_a;
      logic signed [15:0] sin_b;
      logic signed [15:0] cos_b;
      logic signed [15:0] sin_c;
      logic signed [15:0] cos_c;
      logic [9:0]         object_distance;
      logic [7:0]         viewer_distance;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      sin_a: 16'sd0, cos_a: 16'sd16384,
      sin_b: 16'sd0, cos_b: 16'sd16384,
      sin_c: 16'sd0, cos_c: 16'sd16384,
      object_distance: 10'd100, viewer_distance: 8'd40
   };

   typedef struct packed {
      logic              action;
      logic signed [6:0] point_x;
      logic signed [6:0] point_y;
      logic signed [6:0] point_z;
      logic [7:0]        symbol_in;
      logic [11:0]       cell_index;
   } req_type;

   typedef struct packed {
      step_type step;
      logic     push;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_last;
      logic behind;
      logic near;
      logic off;
      logic oob;
      logic req_read;
      logic out_free;
   } sts_type;

endpackage

[src/rppz_if.sv]
// request and response channel interfaces of the point plotter
`timescale 1ns / 1ps

interface rppz_req_if;
   logic              valid;
   logic              ready;
   logic              action;
   logic signed [6:0] point_x;
   logic signed [6:0] point_y;
   logic signed [6:0] point_z;
   logic [7:0]        symbol_in;
   logic [11:0]       cell_index;

   modport source (output valid, action, point_x, point_y, point_z, symbol_in,
                   cell_index, input ready);
   modport sink (input valid, action, point_x, point_y, point_z, symbol_in,
                 cell_index, output ready);
endinterface

interface rppz_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [11:0] pixel_index;
   logic [7:0]  symbol_out;

   modport source (output valid, status, pixel_index, symbol_out, input ready);
   modport sink (input valid, status, pixel_index, symbol_out, output ready);
endinterface

[src/rotate_project_zbuffer_plot.sv]
// Z-buffered point plotter. A plot request rotates a 3D point by the Euler
// matrix held in the sine and cosine registers, adds the object distance, forms
// the reciprocal depth with a radix-2 restoring divider (one quotient bit per
// cycle), projects onto the screen and does a read-modify-write depth test on
// one store RAM. A plot request skips the divider when the depth is so near that
// the reciprocal saturates, and skips projection and the store when the point is
// behind the viewer. One request is in work at a time; the output register
// lets the next request in while a response waits. After reset a clearing pass
// writes all SCREEN_WIDTH*SCREEN_HEIGHT cells (3520 by default) of the store
// before the first request is accepted; configuration writes are taken throughout.
`timescale 1ns / 1ps

module rotate_project_zbuffer_plot #(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 44
) (
   input  logic                        clock,
   input  logic                        reset,
   rppz_req_if.sink                    req_chan,
   rppz_rsp_if.source                  rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [rppz_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   rppz_pkg::cfg_type cfg;
   rppz_pkg::cmd_type cmd;
   rppz_pkg::sts_type sts;
   rppz_pkg::req_type req;

   // request payload
   assign req.action     = req_chan.action;
   assign req.point_x    = req_chan.point_x;
   assign req.point_y    = req_chan.point_y;
   assign req.point_z    = req_chan.point_z;
   assign req.symbol_in  = req_chan.symbol_in;
   assign req.cell_index = req_chan.cell_index;

   rppz_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   rppz_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rppz_dp #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg),
      .req             (req),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_status      (rsp_chan.status),
      .rsp_pixel_index (rsp_chan.pixel_index),
      .rsp_symbol_out  (rsp_chan.symbol_out),
      .sts             (sts)
   );

endmodule

[src/rppz_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps

module rppz_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 3520
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[src/rppz_csr.sv]
// configuration registers behind the apb port
`timescale 1ns / 1ps

module rppz_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rppz_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output rppz_pkg::cfg_type           cfg
);

   rppz_pkg::cfg_type       cfg_ff;
   rppz_pkg::reg_index_type index;
   logic                    wr_en;

   assign index  = rppz_pkg::reg_index_type'(paddr[rppz_pkg::CSR_AW-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= rppz_pkg::CFG_RESET;
      end else if (wr_en) begin
         unique case (index)
            rppz_pkg::REG_SIN_A:     cfg_ff.sin_a <= pwdata[15:0];
            rppz_pkg::REG_COS_A:     cfg_ff.cos_a <= pwdata[15:0];
            rppz_pkg::REG_SIN_B:     cfg_ff.sin_b <= pwdata[15:0];
            rppz_pkg::REG_COS_B:     cfg_ff.cos_b <= pwdata[15:0];
            rppz_pkg::REG_SIN_C:     cfg_ff.sin_c <= pwdata[15:0];
            rppz_pkg::REG_COS_C:     cfg_ff.cos_c <= pwdata[15:0];
            rppz_pkg::REG_OBJ_DIST:  cfg_ff.object_distance <= pwdata[9:0];
            rppz_pkg::REG_VIEW_DIST: cfg_ff.viewer_distance <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (index)
         rppz_pkg::REG_SIN_A:     prdata = 32'(cfg_ff.sin_a);
         rppz_pkg::REG_COS_A:     prdata = 32'(cfg_ff.cos_a);
         rppz_pkg::REG_SIN_B:     prdata = 32'(cfg_ff.sin_b);
         rppz_pkg::REG_COS_B:     prdata = 32'(cfg_ff.cos_b);
         rppz_pkg::REG_SIN_C:     prdata = 32'(cfg_ff.sin_c);
         rppz_pkg::REG_COS_C:     prdata = 32'(cfg_ff.cos_c);
         rppz_pkg::REG_OBJ_DIST:  prdata = {22'd0, cfg_ff.object_distance};
         rppz_pkg::REG_VIEW_DIST: prdata = {24'd0, cfg_ff.viewer_distance};
         default:                 prdata = 32'd0;
      endcase
   end

endmodule

[src/rppz_ctrl.sv]
// sequencing state machine of the point plotter
`timescale 1ns / 1ps
`include "rotate_project_zbuffer_plot_defines.svh"

module rppz_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rppz_pkg::sts_type sts,
   output rppz_pkg::cmd_type cmd
);

   rppz_pkg::state_type state_ff;
   rppz_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rppz_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rppz_pkg::ST_CLEAR:   if (sts.clr_last) state_in = rppz_pkg::ST_IDLE;
         rppz_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = sts.req_read ? rppz_pkg::ST_CLR_RD : rppz_pkg::ST_ROT1;
            end
         end
         rppz_pkg::ST_ROT1:    state_in = rppz_pkg::ST_ROT2;
         rppz_pkg::ST_ROT2:    state_in = rppz_pkg::ST_ROT3;
         rppz_pkg::ST_ROT3:    state_in = rppz_pkg::ST_ROT4;
         rppz_pkg::ST_ROT4:    state_in = rppz_pkg::ST_ROT5;
         rppz_pkg::ST_ROT5:    state_in = rppz_pkg::ST_ROT6;
         rppz_pkg::ST_ROT6:    state_in = rppz_pkg::ST_ROT7;
         rppz_pkg::ST_ROT7: begin
            if (sts.behind) begin
               state_in = rppz_pkg::ST_DROP;
            end else if (sts.near) begin
               state_in = rppz_pkg::ST_PRJ1;
            end else begin
               state_in = rppz_pkg::ST_DIV;
            end
         end
         rppz_pkg::ST_DROP:    state_in = rppz_pkg::ST_DONE;
         rppz_pkg::ST_DIV:     if (sts.div_last) state_in = rppz_pkg::ST_PRJ1;
         rppz_pkg::ST_PRJ1:    state_in = rppz_pkg::ST_PRJ2;
         rppz_pkg::ST_PRJ2:    state_in = rppz_pkg::ST_PRJ3;
         rppz_pkg::ST_PRJ3:    state_in = rppz_pkg::ST_PRJ4;
         rppz_pkg::ST_PRJ4:    state_in = rppz_pkg::ST_PRJ5;
         rppz_pkg::ST_PRJ5:    state_in = rppz_pkg::ST_MEM_RD;
         rppz_pkg::ST_MEM_RD:
            state_in = sts.off ? rppz_pkg::ST_DONE : rppz_pkg::ST_MEM_UPD;
         rppz_pkg::ST_MEM_UPD: state_in = rppz_pkg::ST_DONE;
         rppz_pkg::ST_CLR_RD:
            state_in = sts.oob ? rppz_pkg::ST_DONE : rppz_pkg::ST_CLR_UPD;
         rppz_pkg::ST_CLR_UPD: state_in = rppz_pkg::ST_DONE;
         rppz_pkg::ST_DONE:    if (sts.out_free) state_in = rppz_pkg::ST_IDLE;
         default:              state_in = rppz_pkg::ST_CLEAR;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd.step  = rppz_pkg::STEP_NONE;
      cmd.push  = 1'b0;
      req_ready = 1'b0;
      unique case (state_ff)
         rppz_pkg::ST_CLEAR:   cmd.step = rppz_pkg::STEP_CLEAR;
         rppz_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.step = rppz_pkg::STEP_LOAD;
         end
         rppz_pkg::ST_ROT1:    cmd.step = rppz_pkg::STEP_ROT1;
         rppz_pkg::ST_ROT2:    cmd.step = rppz_pkg::STEP_ROT2;
         rppz_pkg::ST_ROT3:    cmd.step = rppz_pkg::STEP_ROT3;
         rppz_pkg::ST_ROT4:    cmd.step = rppz_pkg::STEP_ROT4;
         rppz_pkg::ST_ROT5:    cmd.step = rppz_pkg::STEP_ROT5;
         rppz_pkg::ST_ROT6:    cmd.step = rppz_pkg::STEP_ROT6;
         rppz_pkg::ST_ROT7:    cmd.step = rppz_pkg::STEP_ROT7;
         rppz_pkg::ST_DROP:    cmd.step = rppz_pkg::STEP_DROP;
         rppz_pkg::ST_DIV:     cmd.step = rppz_pkg::STEP_DIV;
         rppz_pkg::ST_PRJ1:    cmd.step = rppz_pkg::STEP_ZV;
         rppz_pkg::ST_PRJ2:    cmd.step = rppz_pkg::STEP_PX;
         rppz_pkg::ST_PRJ3:    cmd.step = rppz_pkg::STEP_PY;
         rppz_pkg::ST_PRJ4:    cmd.step = rppz_pkg::STEP_COLROW;
         rppz_pkg::ST_PRJ5:    cmd.step = rppz_pkg::STEP_PIX;
         rppz_pkg::ST_MEM_RD:
            cmd.step = sts.off ? rppz_pkg::STEP_DROP : rppz_pkg::STEP_RD_PIX;
         rppz_pkg::ST_MEM_UPD: cmd.step = rppz_pkg::STEP_UPD_PIX;
         rppz_pkg::ST_CLR_RD:  cmd.step = rppz_pkg::STEP_RD_CELL;
         rppz_pkg::ST_CLR_UPD: cmd.step = rppz_pkg::STEP_UPD_CELL;
         rppz_pkg::ST_DONE:    cmd.push = sts.out_free;
         default:              cmd.step = rppz_pkg::STEP_NONE;
      endcase
   end

   // checks
   `RPPZ_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, state_ff != rppz_pkg::ST_IDLE, "accepted request did not start work")
   `RPPZ_ASSERT_NOW(a_push_needs_room, clock, reset, cmd.push, sts.out_free, "response pushed into a full output register")
   `RPPZ_ASSERT_NOW(a_div_entry, clock, reset, state_ff == rppz_pkg::ST_DIV, $past(state_ff) == rppz_pkg::ST_ROT7 || $past(state_ff) == rppz_pkg::ST_DIV, "divider entered without setup")

endmodule

[src/rppz_dp.sv]
// rotation, reciprocal, projection and depth store datapath
`timescale 1ns / 1ps

module rppz_dp #(
   parameter int SCREEN_WIDTH  = 80,
   parameter int SCREEN_HEIGHT = 44
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rppz_pkg::cmd_type             cmd,
   input  rppz_pkg::cfg_type             cfg,
   input  rppz_pkg::req_type             req,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [rppz_pkg::PIX_W-1:0]    rsp_pixel_index,
   output logic [rppz_pkg::SYM_W-1:0]    rsp_symbol_out,
   output rppz_pkg::sts_type             sts
);

   localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam logic [31:0] CELLS_U = 32'(CELLS);
   localparam logic signed [rppz_pkg::P_W-1:0] CELLS_S = rppz_pkg::P_W'(CELLS);
   localparam logic signed [rppz_pkg::P_W-1:0] WIDTH_S = rppz_pkg::P_W'(SCREEN_WIDTH);
   localparam logic signed [rppz_pkg::T_W-1:0] X_CTR =
      rppz_pkg::T_W'(SCREEN_WIDTH / 2) <<< 38;
   localparam logic signed [rppz_pkg::T_W-1:0] Y_CTR =
      rppz_pkg::T_W'(SCREEN_HEIGHT / 2) <<< 38;
   localparam logic signed [rppz_pkg::T_W-1:0] ROUND_UP =
      (rppz_pkg::T_W'(1) <<< 38) - rppz_pkg::T_W'(1);

   rppz_pkg::req_type req_ff;

   logic signed [rppz_pkg::PROD1_W-1:0] p1_ff, p2_ff, p3_ff, p4_ff, q_ff, isb_ff;
   logic signed [rppz_pkg::UV_W-1:0]    u_ff, v_ff;
   logic signed [rppz_pkg::W_W-1:0]     w_ff, cbu_ff, cv_ff, sv_ff;
   logic signed [rppz_pkg::M_W-1:0]     m_ff;
   logic signed [rppz_pkg::CM_W-1:0]    cm_ff, sm_ff;
   logic signed [rppz_pkg::Z14_W-1:0]   z14_ff;
   logic signed [rppz_pkg::XY14_W-1:0]  x14_ff, y14_ff;
   logic [rppz_pkg::DIV_W-1:0]          rem_ff;
   logic [4:0]                          div_cnt_ff;
   logic [rppz_pkg::DEPTH_W-1:0]        zinv_ff;
   logic [rppz_pkg::ZV_W-1:0]           zv_ff;
   logic signed [rppz_pkg::PROJ_W-1:0]  px_ff, py_ff;
   logic signed [rppz_pkg::CR_W-1:0]    col_ff, row_ff;
   logic signed [rppz_pkg::P_W-1:0]     p_ff;
   logic [AW-1:0]                       clr_cnt_ff;

   rppz_pkg::status_type                res_status_ff;
   logic [rppz_pkg::PIX_W-1:0]          res_pixel_ff;
   logic [rppz_pkg::SYM_W-1:0]          res_symbol_ff;
   logic                                rsp_valid_ff;
   rppz_pkg::status_type                rsp_status_ff;
   logic [rppz_pkg::PIX_W-1:0]          rsp_pixel_ff;
   logic [rppz_pkg::SYM_W-1:0]          rsp_symbol_ff;

   logic signed [rppz_pkg::Z42_W-1:0]   z42;
   logic signed [rppz_pkg::ROT_W-1:0]   x42, y42;
   logic [rppz_pkg::DIV_W-1:0]          divisor;
   logic [rppz_pkg::DIV_W:0]            rem2;
   logic                                rem_ge;
   logic signed [rppz_pkg::XY14_W-1:0]  mul_a;
   logic signed [rppz_pkg::ZV_W:0]      mul_b;
   logic signed [rppz_pkg::PROJ_W-1:0]  mul_p;
   logic signed [rppz_pkg::T_W-1:0]     tx, ty, tx_r, ty_r;
   logic [31:0]                         cell_ext;
   logic [AW-1:0]                       cell_addr, pix_addr;
   logic                                nearer, off, oob;
   logic                                ram_wr_en;
   logic [AW-1:0]                       ram_wr_addr, ram_rd_addr;
   logic [rppz_pkg::WORD_W-1:0]         ram_wr_data, ram_rd_data;

   // rotation sums
   assign z42 = (rppz_pkg::Z42_W'(isb_ff) <<< 28) - (rppz_pkg::Z42_W'(cbu_ff) <<< 14);
   assign x42 = rppz_pkg::ROT_W'(cm_ff) + (rppz_pkg::ROT_W'(sv_ff) <<< 14);
   assign y42 = (rppz_pkg::ROT_W'(cv_ff) <<< 14) - rppz_pkg::ROT_W'(sm_ff);

   // one restoring division step
   assign divisor = z14_ff[rppz_pkg::DIV_W-1:0];
   assign rem2    = {rem_ff, 1'b0};
   assign rem_ge  = rem2 >= {1'b0, divisor};

   // shared projection multiplier
   assign mul_a = (cmd.step == rppz_pkg::STEP_PY) ? y14_ff : x14_ff;
   assign mul_b = $signed({1'b0, zv_ff});
   assign mul_p = mul_a * mul_b;

   // screen offsets, truncated toward zero
   assign tx   = X_CTR + (rppz_pkg::T_W'(px_ff) <<< 1);
   assign ty   = Y_CTR - rppz_pkg::T_W'(py_ff);
   assign tx_r = tx + (tx[rppz_pkg::T_W-1] ? ROUND_UP : '0);
   assign ty_r = ty + (ty[rppz_pkg::T_W-1] ? ROUND_UP : '0);

   // addresses and range checks
   assign cell_ext  = {20'd0, req_ff.cell_index};
   assign cell_addr = cell_ext[AW-1:0];
   assign pix_addr  = p_ff[AW-1:0];
   assign off       = (p_ff < 0) || (p_ff >= CELLS_S);
   assign oob       = cell_ext >= CELLS_U;
   assign nearer    = ram_rd_data[rppz_pkg::WORD_W-1:rppz_pkg::SYM_W] < zinv_ff;

   // status to the controller
   assign sts.clr_last = clr_cnt_ff == AW'(CELLS - 1);
   assign sts.div_last = div_cnt_ff == 5'd0;
   assign sts.behind   = z14_ff <= 0;
   assign sts.near     = z14_ff <= rppz_pkg::Z14_W'(16384);
   assign sts.off      = off;
   assign sts.oob      = oob;
   assign sts.req_read = req.action == rppz_pkg::ACTION_READ;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   // store port control
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cell_addr;
      ram_wr_data = {{rppz_pkg::DEPTH_W{1'b0}}, rppz_pkg::SPACE_CODE};
      ram_rd_addr = (cmd.step == rppz_pkg::STEP_RD_CELL) ? cell_addr : pix_addr;
      case (cmd.step)
         rppz_pkg::STEP_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
         end
         rppz_pkg::STEP_UPD_PIX: begin
            ram_wr_en   = nearer;
            ram_wr_addr = pix_addr;
            ram_wr_data = {zinv_ff, req_ff.symbol_in};
         end
         rppz_pkg::STEP_UPD_CELL: ram_wr_en = 1'b1;
         default: ;
      endcase
   end

   rppz_ram #(
      .WIDTH (rppz_pkg::WORD_W),
      .DEPTH (CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // clearing sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.step == rppz_pkg::STEP_CLEAR) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   // arithmetic steps
   always_ff @(posedge clock) begin
      case (cmd.step)
         rppz_pkg::STEP_LOAD: req_ff <= req;
         rppz_pkg::STEP_ROT1: begin
            p1_ff  <= req_ff.point_y * cfg.sin_a;
            p2_ff  <= req_ff.point_z * cfg.cos_a;
            p3_ff  <= req_ff.point_y * cfg.cos_a;
            p4_ff  <= req_ff.point_z * cfg.sin_a;
            q_ff   <= req_ff.point_x * cfg.cos_b;
            isb_ff <= req_ff.point_x * cfg.sin_b;
         end
         rppz_pkg::STEP_ROT2: begin
            u_ff <= rppz_pkg::UV_W'(p1_ff) - rppz_pkg::UV_W'(p2_ff);
            v_ff <= rppz_pkg::UV_W'(p3_ff) + rppz_pkg::UV_W'(p4_ff);
         end
         rppz_pkg::STEP_ROT3: begin
            w_ff   <= cfg.sin_b * u_ff;
            cbu_ff <= cfg.cos_b * u_ff;
         end
         rppz_pkg::STEP_ROT4: begin
            m_ff   <= rppz_pkg::M_W'(w_ff) + (rppz_pkg::M_W'(q_ff) <<< 14);
            z14_ff <= rppz_pkg::Z14_W'(z42 >>> 28)
                      + rppz_pkg::Z14_W'({cfg.object_distance, 14'd0});
         end
         rppz_pkg::STEP_ROT5: begin
            cm_ff <= cfg.cos_c * m_ff;
            sm_ff <= cfg.sin_c * m_ff;
         end
         rppz_pkg::STEP_ROT6: begin
            cv_ff <= cfg.cos_c * v_ff;
            sv_ff <= cfg.sin_c * v_ff;
         end
         rppz_pkg::STEP_ROT7: begin
            x14_ff     <= rppz_pkg::XY14_W'(x42 >>> 28);
            y14_ff     <= rppz_pkg::XY14_W'(y42 >>> 28);
            zinv_ff    <= sts.near ? rppz_pkg::ZINV_MAX : '0;
            rem_ff     <= rppz_pkg::DIV_W'(16384);
            div_cnt_ff <= 5'd23;
         end
         rppz_pkg::STEP_DIV: begin
            rem_ff     <= rem_ge ? rem2[rppz_pkg::DIV_W-1:0] - divisor
                                 : rem2[rppz_pkg::DIV_W-1:0];
            zinv_ff    <= {zinv_ff[rppz_pkg::DEPTH_W-2:0], rem_ge};
            div_cnt_ff <= div_cnt_ff - 5'd1;
         end
         rppz_pkg::STEP_ZV: zv_ff <= rppz_pkg::ZV_W'(zinv_ff) * rppz_pkg::ZV_W'(cfg.viewer_distance);
         rppz_pkg::STEP_PX: px_ff <= mul_p;
         rppz_pkg::STEP_PY: py_ff <= mul_p;
         rppz_pkg::STEP_COLROW: begin
            col_ff <= rppz_pkg::CR_W'(tx_r >>> 38);
            row_ff <= rppz_pkg::CR_W'(ty_r >>> 38);
         end
         rppz_pkg::STEP_PIX:
            p_ff <= rppz_pkg::P_W'(col_ff) + rppz_pkg::P_W'(row_ff) * WIDTH_S;
         default: ;
      endcase
   end

   // result of the current request
   always_ff @(posedge clock) begin
      case (cmd.step)
         rppz_pkg::STEP_DROP: begin
            res_status_ff <= rppz_pkg::STATUS_DROPPED;
            res_pixel_ff  <= '0;
            res_symbol_ff <= '0;
         end
         rppz_pkg::STEP_RD_CELL: begin
            res_status_ff <= rppz_pkg::STATUS_READ;
            res_pixel_ff  <= '0;
            res_symbol_ff <= rppz_pkg::SPACE_CODE;
         end
         rppz_pkg::STEP_UPD_CELL: begin
            res_status_ff <= rppz_pkg::STATUS_READ;
            res_pixel_ff  <= req_ff.cell_index;
            res_symbol_ff <= ram_rd_data[rppz_pkg::SYM_W-1:0];
         end
         rppz_pkg::STEP_UPD_PIX: begin
            res_status_ff <= nearer ? rppz_pkg::STATUS_WRITTEN : rppz_pkg::STATUS_HIDDEN;
            res_pixel_ff  <= p_ff[rppz_pkg::PIX_W-1:0];
            res_symbol_ff <= '0;
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_status_ff <= res_status_ff;
         rsp_pixel_ff  <= res_pixel_ff;
         rsp_symbol_ff <= res_symbol_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_pixel_index = rsp_pixel_ff;
   assign rsp_symbol_out  = rsp_symbol_ff;

endmodule

[dv/rotate_project_zbuffer_plot_tb.sv]
// self-checking testbench of the z-buffered point plotter
`timescale 1ns / 1ps

module rotate_project_zbuffer_plot_tb;

   localparam int SCR_W = 80;
   localparam int SCR_H = 44;
   localparam int CELL_COUNT = SCR_W * SCR_H;
   localparam int CYCLE_LIMIT = 1500000;

   // expected response of one request
   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] pixel;
      logic [7:0]  symbol;
   } plot_rsp_type;

   // scoreboard: mirror of the plotter state and the queue of expected responses
   class plot_scoreboard;
      plot_rsp_type pending[$];
      logic signed [15:0] sa, ca, sb, cb, sc, cc;
      logic [9:0] obj_dist;
      logic [7:0] view_dist;
      logic [23:0] depth_mem[CELL_COUNT];
      logic [7:0] sym_mem[CELL_COUNT];
      int mismatches;

      function void clear_all();
         sa = 0; ca = 16384; sb = 0; cb = 16384; sc = 0; cc = 16384;
         obj_dist = 100; view_dist = 40;
         for (int n = 0; n < CELL_COUNT; n++) begin
            depth_mem[n] = '0;
            sym_mem[n] = rppz_pkg::SPACE_CODE;
         end
         mismatches = 0;
      endfunction

      function void set_reg(rppz_pkg::reg_index_type idx, logic [31:0] v);
         case (idx)
            rppz_pkg::REG_SIN_A: sa = v[15:0];
            rppz_pkg::REG_COS_A: ca = v[15:0];
            rppz_pkg::REG_SIN_B: sb = v[15:0];
            rppz_pkg::REG_COS_B: cb = v[15:0];
            rppz_pkg::REG_SIN_C: sc = v[15:0];
            rppz_pkg::REG_COS_C: cc = v[15:0];
            rppz_pkg::REG_OBJ_DIST: obj_dist = v[9:0];
            rppz_pkg::REG_VIEW_DIST: view_dist = v[7:0];
            default: ;
         endcase
      endfunction

      // floor division by 2^28 of an exact Q42 value
      function longint floor28(longint v);
         return v >>> 28;
      endfunction

      function void note_request(rppz_pkg::req_type r);
         plot_rsp_type e;
         longint i, j, k, x42, y42, z42, x14, y14, z14, col, row, p, zinv;
         longint s14, s28, lsa, lca, lsb, lcb, lsc, lcc;
         logic signed [127:0] t;
         s14 = 16384; s28 = 64'sd1 << 28;
         e = '0;
         if (r.action == rppz_pkg::ACTION_READ) begin
            e.status = rppz_pkg::STATUS_READ;
            if (r.cell_index < CELL_COUNT) begin
               e.pixel = r.cell_index;
               e.symbol = sym_mem[r.cell_index];
               sym_mem[r.cell_index] = rppz_pkg::SPACE_CODE;
               depth_mem[r.cell_index] = '0;
            end else
               e.symbol = rppz_pkg::SPACE_CODE;
            pending.push_back(e);
            return;
         end
         i = r.point_x; j = r.point_y; k = r.point_z;
         lsa = sa; lca = ca; lsb = sb; lcb = cb; lsc = sc; lcc = cc;
         x42 = j * lsa * lsb * lcc - k * lca * lsb * lcc
               + (j * lca * lsc + k * lsa * lsc) * s14 + i * lcb * lcc * s14;
         y42 = (j * lca * lcc + k * lsa * lcc) * s14 - j * lsa * lsb * lsc
               + k * lca * lsb * lsc - i * lcb * lsc * s14;
         z42 = (k * lca * lcb - j * lsa * lcb) * s14 + i * lsb * s28;
         x14 = floor28(x42);
         y14 = floor28(y42);
         z14 = floor28(z42) + longint'(obj_dist) * s14;
         if (z14 <= 0) begin
            e.status = rppz_pkg::STATUS_DROPPED;
            pending.push_back(e);
            return;
         end
         zinv = (64'sd1 <<< 38) / z14;
         if (zinv > 64'sh FFFFFF) zinv = 64'sh FFFFFF;
         t = (128'sd40 <<< 38) + 128'(x14) * zinv * longint'(view_dist) * 2;
         col = longint'(t / (128'sd1 <<< 38));
         t = (128'sd22 <<< 38) - 128'(y14) * zinv * longint'(view_dist);
         row = longint'(t / (128'sd1 <<< 38));
         p = col + row * SCR_W;
         if (p < 0 || p >= CELL_COUNT) begin
            e.status = rppz_pkg::STATUS_DROPPED;
            pending.push_back(e);
            return;
         end
         e.pixel = p[11:0];
         if (longint'(depth_mem[p]) < zinv) begin
            depth_mem[p] = zinv[23:0];
            sym_mem[p] = r.symbol_in;
            e.status = rppz_pkg::STATUS_WRITTEN;
         end else
            e.status = rppz_pkg::STATUS_HIDDEN;
         pending.push_back(e);
      endfunction

      function void check_response(plot_rsp_type got);
         plot_rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         e = pending.pop_front();
         if (e != got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected status %0d pixel %0d symbol %0d, got %0d %0d %0d",
                        e.status, e.pixel, e.symbol, got.status, got.pixel, got.symbol);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [rppz_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   longint cycle_count = 0;
   bit hold_rsp = 1'b0;
   bit stim_done = 1'b0;

   rppz_req_if req_chan();
   rppz_rsp_if rsp_chan();
   plot_scoreboard plot_sb;

   rotate_project_zbuffer_plot dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.action = 1'b0;
      req_chan.point_x = '0;
      req_chan.point_y = '0;
      req_chan.point_z = '0;
      req_chan.symbol_in = '0;
      req_chan.cell_index = '0;
      rsp_chan.ready = 1'b0;
      plot_sb = new();
      plot_sb.clear_all();
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // response side: random stalls, plus a long hold-off on request
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = stim_done ? 0 : pick_gap();
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         plot_sb.check_response('{rsp_chan.status, rsp_chan.pixel_index,
                                  rsp_chan.symbol_out});
   end

   task automatic write_reg(rppz_pkg::reg_index_type idx, logic [31:0] v);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= rppz_pkg::CSR_AW'(idx) << 2; csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock iff csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      plot_sb.set_reg(idx, v);
   endtask

   task automatic send_request(rppz_pkg::req_type r, int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.action <= r.action;
      req_chan.point_x <= r.point_x;
      req_chan.point_y <= r.point_y;
      req_chan.point_z <= r.point_z;
      req_chan.symbol_in <= r.symbol_in;
      req_chan.cell_index <= r.cell_index;
      @(posedge clock iff req_chan.ready);
      plot_sb.note_request(r);
   endtask

   // drain: wait for every response, then the plot latency
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock iff plot_sb.pending.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   function automatic rppz_pkg::req_type rand_plot();
      rppz_pkg::req_type r;
      r = '0;
      r.action = 1'b0;
      r.point_x = 7'($urandom); r.point_y = 7'($urandom); r.point_z = 7'($urandom);
      r.symbol_in = 8'($urandom);
      r.cell_index = 12'($urandom);
      return r;
   endfunction

   function automatic rppz_pkg::req_type rand_read();
      rppz_pkg::req_type r;
      r = rand_plot();
      r.action = rppz_pkg::ACTION_READ;
      r.cell_index = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(CELL_COUNT, 4095))
                                                 : 12'($urandom_range(0, CELL_COUNT - 1));
      return r;
   endfunction

   function automatic logic [15:0] rand_trig();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         3: return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // stimulus
   initial begin
      rppz_pkg::req_type r;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, extremes, near depth, behind, reads
      r = '0; send_request(r, 0);
      r.point_x = 7'(63); r.point_y = 7'(-64); r.point_z = 7'(63); r.symbol_in = 8'hFF;
      send_request(r, 0);
      r.point_x = 7'(-64); r.point_y = 7'(63); r.point_z = 7'(-64); r.symbol_in = 8'h00;
      send_request(r, 1);
      r = '0; r.symbol_in = 8'h41; send_request(r, 0);  // hidden at same depth
      r = '0; r.action = rppz_pkg::ACTION_READ; r.cell_index = 12'(22 * SCR_W + 40);
      send_request(r, 0);
      r.cell_index = 12'hFFF; send_request(r, 0);
      r.cell_index = 12'(CELL_COUNT - 1); send_request(r, 0);
      r.cell_index = '0; send_request(r, 0);
      wait_idle();
      write_reg(rppz_pkg::REG_OBJ_DIST, 1); write_reg(rppz_pkg::REG_VIEW_DIST, 255);
      write_reg(rppz_pkg::REG_SIN_B, 16384); write_reg(rppz_pkg::REG_COS_B, 0);
      r = '0; r.point_x = 7'(-64); send_request(r, 0);     // behind viewer
      r.point_x = '0; send_request(r, 0);                  // very near depth
      r.point_x = 7'(63); r.point_y = 7'(5); send_request(r, 0);
      wait_idle();
      write_reg(rppz_pkg::REG_VIEW_DIST, 0); write_reg(rppz_pkg::REG_SIN_A, -16384);
      write_reg(rppz_pkg::REG_COS_A, 16'h8000); write_reg(rppz_pkg::REG_SIN_C, 16'h7FFF);
      write_reg(rppz_pkg::REG_COS_C, -16384); write_reg(rppz_pkg::REG_OBJ_DIST, 1023);
      r = '0; r.point_x = 7'(40); r.point_y = 7'(-30); r.symbol_in = 8'h55;
      send_request(r, 0);
      r.point_z = 7'(-64); send_request(r, 0);
      wait_idle();

      // random phases with fresh settings
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(rppz_pkg::REG_SIN_A, rand_trig());
         write_reg(rppz_pkg::REG_COS_A, rand_trig());
         write_reg(rppz_pkg::REG_SIN_B, rand_trig());
         write_reg(rppz_pkg::REG_COS_B, rand_trig());
         write_reg(rppz_pkg::REG_SIN_C, rand_trig());
         write_reg(rppz_pkg::REG_COS_C, rand_trig());
         write_reg(rppz_pkg::REG_OBJ_DIST, (ph == 0) ? 1 : $urandom_range(1, 1023));
         write_reg(rppz_pkg::REG_VIEW_DIST, (ph == 1) ? 255 : $urandom_range(1, 255));
         if (ph == 2) hold_rsp = 1'b1;
         for (int n = 0; n < 75; n++) begin
            r = ($urandom_range(0, 3) == 0) ? rand_read() : rand_plot();
            send_request(r, pick_gap());
         end
         wait_idle();
      end
      stim_done = 1'b1;
      if (plot_sb.mismatches == 0 && plot_sb.pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[rotate_project_zbuffer_plot.f]
+incdir+src
src/rppz_pkg.sv
src/rppz_if.sv
src/rppz_ram.sv
src/rppz_csr.sv
src/rppz_ctrl.sv
src/rppz_dp.sv
src/rotate_project_zbuffer_plot.sv
dv/rotate_project_zbuffer_plot_tb.sv
